### sv/gbr_pkg.sv
package gbr_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 128;

    localparam logic [8:0] PANEL_W_LIM = 9'(PANEL_WIDTH);
    localparam logic [8:0] PANEL_H_LIM = 9'(PANEL_HEIGHT);

    localparam int BYTE_BITS = 8;

    localparam logic [5:0] HEIGHT_SMALL  = 6'd16;
    localparam logic [5:0] HEIGHT_MID    = 6'd24;
    localparam logic [5:0] HEIGHT_LARGE  = 6'd32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        REG_GLYPH_HEIGHT = 3'd0,
        REG_TRANSPARENT  = 3'd1,
        REG_FG_COLOR     = 3'd2,
        REG_BG_COLOR     = 3'd3,
        REG_COL_OFFSET   = 3'd4,
        REG_ROW_OFFSET   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [5:0]  glyph_height;
        logic        transparent;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic [6:0]  col_offset;
        logic [6:0]  row_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        glyph_height: 6'd16,
        transparent:  1'b0,
        fg_color:     16'h0000,
        bg_color:     16'hFFFF,
        col_offset:   7'd2,
        row_offset:   7'd1
    };

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row_base;
        logic [BYTE_BITS-1:0] emit;
        logic [BYTE_BITS-1:0] fgsel;
    } job_t;

endpackage

### sv/gbr_if.sv
interface gbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

interface gbr_glyph_if;
    logic       valid;
    logic       ready;
    logic [7:0] glyph_byte;
    logic       glyph_start;
    logic [7:0] origin_x;
    logic [7:0] origin_y;

    modport source (output valid, output glyph_byte, output glyph_start,
                    output origin_x, output origin_y, input ready);
    modport sink (input valid, input glyph_byte, input glyph_start,
                  input origin_x, input origin_y, output ready);
endinterface

interface gbr_pixel_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_col;
    logic [7:0]  pixel_row;
    logic [15:0] pixel_color;
    logic        last_of_byte;

    modport source (output valid, output pixel_col, output pixel_row,
                    output pixel_color, output last_of_byte, input ready);
    modport sink (input valid, input pixel_col, input pixel_row,
                  input pixel_color, input last_of_byte, output ready);
    modport monitor (input valid, input pixel_col, input pixel_row,
                     input pixel_color, input last_of_byte, input ready);
endinterface

### sv/gbr_cfg_regs.sv
module gbr_cfg_regs
    import gbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gbr_cfg_if.sink   cfg_wr,
    output cfg_t      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_wr.ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr.valid)
        begin
            case (cfg_wr.reg_index)
                REG_GLYPH_HEIGHT: cfg_next.glyph_height = cfg_wr.wdata[5:0];
                REG_TRANSPARENT:  cfg_next.transparent  = cfg_wr.wdata[0];
                REG_FG_COLOR:     cfg_next.fg_color     = cfg_wr.wdata;
                REG_BG_COLOR:     cfg_next.bg_color     = cfg_wr.wdata;
                REG_COL_OFFSET:   cfg_next.col_offset   = cfg_wr.wdata[6:0];
                REG_ROW_OFFSET:   cfg_next.row_offset   = cfg_wr.wdata[6:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/gbr_front.sv
module gbr_front
    import gbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gbr_glyph_if.sink glyph_in,
    input  cfg_t      cfg,
    input  logic      fifo_full,
    output logic      push,
    output job_t      job
);

    logic [7:0] cursor_x_reg;
    logic [7:0] cursor_x_next;
    logic [7:0] cursor_y_reg;
    logic [7:0] cursor_y_next;
    logic [7:0] column_top_reg;
    logic [7:0] column_top_next;
    logic       aborted_reg;
    logic       aborted_next;

    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] top;
    logic       ab;
    logic       height_ok;
    logic       walk;
    logic       accept;
    logic       found;
    logic       stop_bottom;
    logic [8:0] ny [BYTE_BITS];
    logic [8:0] ny_stop;
    logic [BYTE_BITS-1:0] bottom;
    logic [BYTE_BITS-1:0] colend;
    logic [BYTE_BITS-1:0] processed;
    logic [BYTE_BITS-1:0] emit;
    logic [8:0] x_plus;

    assign glyph_in.ready = !fifo_full;
    assign accept = glyph_in.valid && glyph_in.ready;

    always_comb
    begin
        x   = glyph_in.glyph_start ? glyph_in.origin_x : cursor_x_reg;
        y   = glyph_in.glyph_start ? glyph_in.origin_y : cursor_y_reg;
        top = glyph_in.glyph_start ? glyph_in.origin_y : column_top_reg;
        ab  = glyph_in.glyph_start ? 1'b0 : aborted_reg;

        height_ok = (cfg.glyph_height == HEIGHT_SMALL) || (cfg.glyph_height == HEIGHT_MID)
                    || (cfg.glyph_height == HEIGHT_LARGE);
        walk = !ab && height_ok;

        for (int i = 0; i < BYTE_BITS; i++)
        begin
            ny[i]     = {1'b0, y} + 9'(i + 1);
            bottom[i] = ny[i] >= PANEL_H_LIM;
            colend[i] = !bottom[i] && ((ny[i][7:0] - top) == {2'b00, cfg.glyph_height});
        end

        found       = 1'b0;
        stop_bottom = 1'b0;
        ny_stop     = '0;
        for (int i = 0; i < BYTE_BITS; i++)
        begin
            processed[i] = !found;
            if (!found && (bottom[i] || colend[i]))
            begin
                found       = 1'b1;
                stop_bottom = bottom[i];
                ny_stop     = ny[i];
            end
        end

        for (int i = 0; i < BYTE_BITS; i++)
        begin
            emit[i] = walk && processed[i]
                      && (glyph_in.glyph_byte[BYTE_BITS-1-i] || !cfg.transparent)
                      && ({1'b0, x} < PANEL_W_LIM)
                      && (({1'b0, y} + 9'(i)) < PANEL_H_LIM);
            job.fgsel[i] = glyph_in.glyph_byte[BYTE_BITS-1-i];
        end

        x_plus = {1'b0, x} + 9'd1;

        cursor_x_next   = x;
        cursor_y_next   = y;
        column_top_next = top;
        aborted_next    = ab;
        if (walk)
        begin
            if (!found)
            begin
                cursor_y_next = y + 8'(BYTE_BITS);
            end
            else if (stop_bottom)
            begin
                cursor_y_next = ny_stop[7:0];
                aborted_next  = 1'b1;
            end
            else
            begin
                cursor_y_next = top;
                cursor_x_next = x_plus[7:0];
                aborted_next  = x_plus >= PANEL_W_LIM;
            end
        end

        job.col      = x + {1'b0, cfg.col_offset};
        job.row_base = y + {1'b0, cfg.row_offset};
        job.emit     = emit;
        push         = accept && (|emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            column_top_reg <= '0;
            aborted_reg    <= 1'b0;
        end
        else if (accept)
        begin
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            column_top_reg <= column_top_next;
            aborted_reg    <= aborted_next;
        end
    end

endmodule

### sv/gbr_queue.sv
module gbr_queue
    import gbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic do_push;
    logic do_pop;

    assign full    = count_reg == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/gbr_back.sv
module gbr_back
    import gbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  job_t        head,
    input  logic        empty,
    output logic        pop,
    gbr_pixel_if.source pixel_out
);

    logic [BYTE_BITS-1:0] mask_reg;
    logic [BYTE_BITS-1:0] mask_next;
    logic [BYTE_BITS-1:0] fgsel_reg;
    logic [BYTE_BITS-1:0] fgsel_next;
    logic [7:0]  col_reg;
    logic [7:0]  col_next;
    logic [7:0]  row_base_reg;
    logic [7:0]  row_base_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_col_reg;
    logic [7:0]  out_col_next;
    logic [7:0]  out_row_reg;
    logic [7:0]  out_row_next;
    logic [15:0] out_color_reg;
    logic [15:0] out_color_next;
    logic        out_last_reg;
    logic        out_last_next;

    logic [$clog2(BYTE_BITS)-1:0] idx;
    logic [BYTE_BITS-1:0] rest;
    logic [BYTE_BITS-1:0] mask_after;
    logic adv;

    assign pixel_out.valid        = out_valid_reg;
    assign pixel_out.pixel_col    = out_col_reg;
    assign pixel_out.pixel_row    = out_row_reg;
    assign pixel_out.pixel_color  = out_color_reg;
    assign pixel_out.last_of_byte = out_last_reg;

    always_comb
    begin
        idx = '0;
        for (int i = BYTE_BITS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                idx = ($clog2(BYTE_BITS))'(i);
            end
        end
        rest       = mask_reg & ~(BYTE_BITS'(1) << idx);
        adv        = (|mask_reg) && (!out_valid_reg || pixel_out.ready);
        mask_after = adv ? rest : mask_reg;
        pop        = (mask_after == '0) && !empty;

        mask_next     = pop ? head.emit : mask_after;
        fgsel_next    = pop ? head.fgsel : fgsel_reg;
        col_next      = pop ? head.col : col_reg;
        row_base_next = pop ? head.row_base : row_base_reg;

        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_col_next   = col_reg;
            out_row_next   = row_base_reg + 8'(idx);
            out_color_next = fgsel_reg[idx] ? cfg.fg_color : cfg.bg_color;
            out_last_next  = rest == '0;
        end
        else if (pixel_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fgsel_reg     <= fgsel_next;
        col_reg       <= col_next;
        row_base_reg  <= row_base_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/glyph_bitmap_rasterizer.sv
// Glyph bitmap rasterizer: turns column-major glyph bitmap bytes into panel pixel writes.
// Configuration is written over cfg_wr (reg_index, wdata); the user must write it only
// while the block is idle, which the block itself does not enforce. That channel is
// always ready and each write takes effect on the next cycle. Bytes arrive on glyph_in;
// a byte with glyph_start set loads a new glyph origin first. Each byte causes zero to
// eight pixel transactions on pixel_out, in bit order from the MSB, and the final one of
// a byte carries last_of_byte. A byte is classified in the cycle it is accepted and,
// if it draws anything, enters a four-entry job queue. The pixel engine takes a job
// from the queue and emits one pixel per cycle into an output register while pixel_out
// is not stalled; the first pixel of a byte passes through the queue, the engine's mask
// register and the output register. Sustained throughput is one pixel per cycle while
// pixel_out is not stalled; bytes that draw nothing cost no engine time. glyph_in is
// ready whenever the queue has room. When pixel_out stalls, the output register holds
// its transaction, the engine waits, and glyph_in keeps accepting bytes until the queue
// fills. Reset clears the cursor, the abort flag, the queue and the output valid flag and
// loads the default configuration.
module glyph_bitmap_rasterizer
    import gbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gbr_cfg_if.sink     cfg_wr,
    gbr_glyph_if.sink   glyph_in,
    gbr_pixel_if.source pixel_out
);

    cfg_t cfg;
    job_t push_job;
    job_t head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    gbr_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .cfg    (cfg)
    );

    gbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .glyph_in  (glyph_in),
        .cfg       (cfg),
        .fifo_full (full),
        .push      (push),
        .job       (push_job)
    );

    gbr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    gbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out)
    );

endmodule

### sv/gbr_checker.sv
module gbr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [7:0]  pixel_col,
    input logic [7:0]  pixel_row,
    input logic [15:0] pixel_color,
    input logic        last_of_byte
);

    // Nothing comes out during or right after reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !valid)
        else $error("pixel output valid after reset");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=>
            valid && $stable(pixel_col)
            && $stable(pixel_row) && $stable(pixel_color)
            && $stable(last_of_byte))
        else $error("stalled pixel transaction changed");

    // Pixels of one byte all lie in the same column, each in a different row.
    a_same_column: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !last_of_byte |=>
            !valid || (pixel_col == $past(pixel_col)))
        else $error("pixel of one byte left its column");

    a_row_moves: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !last_of_byte |=>
            !valid || (pixel_row != $past(pixel_row)))
        else $error("pixel of one byte repeated its row");

endmodule

bind glyph_bitmap_rasterizer gbr_checker u_gbr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (pixel_out.valid),
    .ready        (pixel_out.ready),
    .pixel_col    (pixel_out.pixel_col),
    .pixel_row    (pixel_out.pixel_row),
    .pixel_color  (pixel_out.pixel_color),
    .last_of_byte (pixel_out.last_of_byte)
);
